// ===== rtl/lmld_pkg.sv =====
// Shared types and constants for the LED matrix line drawing block.
package lmld_pkg;

   // Grid geometry
   localparam int GRID_SIZE = 8;
   localparam int COORD_W   = $clog2(GRID_SIZE);
   localparam int STEP_W    = $clog2(GRID_SIZE + 1);
   localparam int ERR_W     = COORD_W + 2;
   localparam int NIBBLE_W  = 4;

   localparam logic [COORD_W-1:0] COORD_MAX   = COORD_W'(GRID_SIZE - 1);
   localparam logic [COORD_W-1:0] HALF_GRID   = COORD_W'(GRID_SIZE / 2);
   localparam logic [COORD_W-1:0] HALF_GRID_M = COORD_W'(GRID_SIZE / 2 - 1);
   localparam logic [STEP_W-1:0]  STEP_LIMIT  = STEP_W'(GRID_SIZE);

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_EMIT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;   // capture target, clear bitmap, plot centre
      logic step;   // advance the line walk by one pixel
      logic emit;   // load the next column word into the output register
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic at_target;   // walk position equals target
      logic walk_done;   // step budget used up
      logic out_free;    // output register can take a word this cycle
      logic emit_last;   // the column about to be emitted is the final one
   } dp_status_type;

   // Saturate a nibble to the top grid coordinate
   function automatic logic [COORD_W-1:0] sat_coord(input logic [NIBBLE_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (v > NIBBLE_W'(COORD_MAX)) begin
         r = COORD_MAX;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   // Centre on one axis, chosen by which half holds the target
   function automatic logic [COORD_W-1:0] centre_of(input logic [COORD_W-1:0] t);
      logic [COORD_W-1:0] r;
      if (t >= HALF_GRID) begin
         r = HALF_GRID;
      end else begin
         r = HALF_GRID_M;
      end
      return r;
   endfunction

endpackage

// ===== rtl/lmld_ctrl.sv =====
// Controller state machine for the LED matrix line drawing block.
module lmld_ctrl
   import lmld_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output state_type     state
);

   state_type state_ff;
   state_type state_in;

   // Hold the current state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Choose the next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.at_target || status.walk_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free && status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Drive datapath commands and the input handshake
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_WALK: begin
            cmd.step = !status.at_target && !status.walk_done;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign state = state_ff;

endmodule

// ===== rtl/lmld_datapath.sv =====
// Datapath: target capture, error-term line walk, bitmap and column output register.
module lmld_datapath
   import lmld_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   input  logic [7:0]    req_target_byte,
   output dp_status_type status,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic [2:0]    rsp_column_index,
   output logic [7:0]    rsp_column_bits,
   output logic          rsp_last_column
);

   // Walk registers
   logic [COORD_W-1:0]      tx_ff, tx_in, ty_ff, ty_in;
   logic [COORD_W-1:0]      x_ff, x_in, y_ff, y_in;
   logic [COORD_W-1:0]      arow_ff, arow_in, acol_ff, acol_in;
   logic                    x_up_ff, x_up_in, y_up_ff, y_up_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [STEP_W-1:0]       steps_ff, steps_in;
   logic [GRID_SIZE-1:0]    bitmap_ff [GRID_SIZE];
   logic [GRID_SIZE-1:0]    bitmap_in [GRID_SIZE];

   // Emission registers
   logic [COORD_W-1:0]      col_ff, col_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_index_ff, rsp_index_in;
   logic [7:0]              rsp_bits_ff, rsp_bits_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Decoded command target
   logic [COORD_W-1:0]      tx_new, ty_new, cx_new, cy_new;

   // Step arithmetic
   logic                    row_major;
   logic [COORD_W-1:0]      major, minor;
   logic signed [ERR_W-1:0] err_add;
   logic                    err_pos;
   logic                    x_step, y_step;
   logic [COORD_W-1:0]      x_next, y_next;

   // Plot port
   logic                    plot_en;
   logic [COORD_W-1:0]      plot_x, plot_y;

   // Decode target and centre from the request word
   always_comb begin
      tx_new = sat_coord(req_target_byte[NIBBLE_W-1:0]);
      ty_new = sat_coord(req_target_byte[2*NIBBLE_W-1:NIBBLE_W]);
      cx_new = centre_of(tx_new);
      cy_new = centre_of(ty_new);
   end

   // Compute one walk step: major axis always, minor axis on positive error
   always_comb begin
      row_major = arow_ff > acol_ff;
      major     = row_major ? arow_ff : acol_ff;
      minor     = row_major ? acol_ff : arow_ff;
      err_add   = err_ff + $signed({2'b00, minor});
      err_pos   = !err_add[ERR_W-1] && (err_add != '0);
      x_step    = row_major ? err_pos : 1'b1;
      y_step    = row_major ? 1'b1 : err_pos;
      x_next    = x_ff;
      y_next    = y_ff;
      if (x_step) begin
         x_next = x_up_ff ? x_ff + COORD_W'(1) : x_ff - COORD_W'(1);
      end
      if (y_step) begin
         y_next = y_up_ff ? y_ff + COORD_W'(1) : y_ff - COORD_W'(1);
      end
   end

   // Update walk state on load and step
   always_comb begin
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      arow_in  = arow_ff;
      acol_in  = acol_ff;
      x_up_in  = x_up_ff;
      y_up_in  = y_up_ff;
      err_in   = err_ff;
      steps_in = steps_ff;
      plot_en  = 1'b0;
      plot_x   = x_next;
      plot_y   = y_next;
      priority if (cmd.load) begin
         tx_in    = tx_new;
         ty_in    = ty_new;
         x_in     = cx_new;
         y_in     = cy_new;
         x_up_in  = tx_new > cx_new;
         y_up_in  = ty_new >= cy_new;
         arow_in  = (ty_new >= cy_new) ? ty_new - cy_new : cy_new - ty_new;
         acol_in  = (tx_new >= cx_new) ? tx_new - cx_new : cx_new - tx_new;
         err_in   = '0;
         steps_in = '0;
         plot_en  = 1'b1;
         plot_x   = cx_new;
         plot_y   = cy_new;
      end else if (cmd.step) begin
         x_in     = x_next;
         y_in     = y_next;
         err_in   = err_pos ? err_add - $signed({2'b00, major}) : err_add;
         steps_in = steps_ff + STEP_W'(1);
         plot_en  = 1'b1;
      end else begin
         plot_en  = 1'b0;
      end
   end

   // Clear the bitmap on load and set the plotted pixel in its column
   always_comb begin
      for (int i = 0; i < GRID_SIZE; i++) begin
         bitmap_in[i] = cmd.load ? '0 : bitmap_ff[i];
         if (plot_en && (plot_x == COORD_W'(i))) begin
            bitmap_in[i][plot_y] = 1'b1;
         end
      end
   end

   // Fill the output register one column word at a time
   always_comb begin
      col_in       = col_ff;
      rsp_index_in = rsp_index_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load) begin
         col_in = '0;
      end
      if (cmd.emit) begin
         rsp_index_in = 3'(col_ff);
         rsp_bits_in  = 8'(bitmap_ff[col_ff]);
         rsp_last_in  = col_ff == COORD_MAX;
         rsp_valid_in = 1'b1;
         col_in       = col_ff + COORD_W'(1);
      end
   end

   // Hold control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      tx_ff        <= tx_in;
      ty_ff        <= ty_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      arow_ff      <= arow_in;
      acol_ff      <= acol_in;
      x_up_ff      <= x_up_in;
      y_up_ff      <= y_up_in;
      err_ff       <= err_in;
      steps_ff     <= steps_in;
      bitmap_ff    <= bitmap_in;
      rsp_index_ff <= rsp_index_in;
      rsp_bits_ff  <= rsp_bits_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Report status to the controller
   always_comb begin
      status.at_target = (x_ff == tx_ff) && (y_ff == ty_ff);
      status.walk_done = steps_ff == STEP_LIMIT;
      status.out_free  = !rsp_valid_ff || rsp_ready;
      status.emit_last = col_ff == COORD_MAX;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_column_index = rsp_index_ff;
   assign rsp_column_bits  = rsp_bits_ff;
   assign rsp_last_column  = rsp_last_ff;

endmodule

// ===== rtl/led_matrix_line_draw.sv =====
// Top level of the LED matrix line drawing block: controller plus datapath.
//
//   channel   direction  handshake              words per command
//   req_      in         req_valid / req_ready  1 (target byte)
//   rsp_      out        rsp_valid / rsp_ready  8 (column index, bits, last flag)
//
// A command is taken only while the controller is idle. It loads the target,
// then walks one pixel per step (up to the major distance, at most three
// here), then emits the eight columns.
// The output register frees the controller after the eighth column is loaded,
// so the next command can be taken while that word still waits.
// Reset is synchronous and active high; it clears the state machine and the
// output valid flag. An output stall holds the controller in its emit state.
module led_matrix_line_draw
   import lmld_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_target_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_column_index,
   output logic [7:0] rsp_column_bits,
   output logic       rsp_last_column
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   state_type     state;

   lmld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   lmld_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_target_byte  (req_target_byte),
      .status           (status),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_column_index (rsp_column_index),
      .rsp_column_bits  (rsp_column_bits),
      .rsp_last_column  (rsp_last_column)
   );

   // An accepted command keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && state == ST_WALK))
      else $error("block took a command but is not walking");

   // The last flag marks only the final column
   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_column == (rsp_column_index == COORD_MAX)))
      else $error("last flag does not match column index");

   // While the first column waits, the block is still emitting
   a_first_col_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_column_index == '0) |-> (state == ST_EMIT))
      else $error("first column shown outside emission");

   // Walking never drives the output register
   a_walk_no_emit: assert property (@(posedge clock) disable iff (reset)
      (state == ST_WALK) |-> !cmd.emit)
      else $error("column emitted during walk");

endmodule
